// ----- design/thcm_pkg.sv -----
`default_nettype none

package thcm_pkg;

   // Width of one signed fixed-point value and its fractional part.
   localparam int VALUE_BITS = 32;
   localparam int Q_FRAC     = 16;

   // Color count register, group index and channel widths.
   localparam int COUNT_BITS = 9;
   localparam int GROUP_BITS = 8;
   localparam int CHAN_BITS  = 8;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_VALUE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VALUE   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_COUNT = 2'd2;

   // Color constants.
   localparam int BASE_LOW  = 120;
   localparam int BASE_HIGH = 255;
   localparam int SPAN      = 135;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] sample_value;
      logic signed [VALUE_BITS-1:0] nominal_value;
      logic                         nominal_given;
   } req_data_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]  red;
      logic [CHAN_BITS-1:0]  green;
      logic [CHAN_BITS-1:0]  blue;
      logic [GROUP_BITS-1:0] value_group;
      logic [GROUP_BITS-1:0] reference_group;
   } rsp_data_type;

endpackage

`default_nettype wire

// ----- design/two_sided_heat_colormap.sv -----
`default_nettype none

// Two-sided heat color map. Each transfer on the request side carries a
// signed Q16.16 sample, a nominal value and a flag that selects the nominal
// value or the truncated midpoint of the configured range as the reference.
// The block finds the group of the sample and of the reference among
// color_count - 1 equal groups of the range, and returns one RGB transfer
// together with both group indexes. A request is taken when start is high
// and busy is low; busy then stays high, and the result appears on rsp_data,
// marked by rsp_valid for exactly one cycle, in the cycle in which busy falls.
// The receiver cannot stall the result, so it must capture every cycle in
// which rsp_valid is high. One shared restoring-division subtractor does the
// divisions: each group search takes up to eight of its steps and the color
// step takes nine. A new request may be started
// in the same cycle in which the previous result is presented. The
// configuration registers should be written only while busy is low and no
// result is pending.
module two_sided_heat_colormap (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire thcm_pkg::req_data_type                 req_data,
   output      logic                                   rsp_valid,
   output      thcm_pkg::rsp_data_type                 rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [thcm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [thcm_pkg::VALUE_BITS-1:0]        csr_wdata
);

   import thcm_pkg::*;

   // Widths of the arithmetic. A difference of two values needs one more
   // bit, and its product with the group count needs the group width plus one.
   localparam int DW     = VALUE_BITS + 1;
   localparam int PW     = DW + GROUP_BITS + 1;
   localparam int UW     = VALUE_BITS + GROUP_BITS;
   localparam int HW     = DW - Q_FRAC;
   localparam int GQ     = GROUP_BITS;
   localparam int CQ     = GROUP_BITS + 1;
   localparam int NUMW   = 17;
   localparam int CNTW   = 4;
   localparam int CW     = CHAN_BITS + 2;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ND   = 3'd1;
   localparam logic [2:0] ST_LHS  = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_CSET = 3'd5;
   localparam logic [2:0] ST_CDIV = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   // Color cases: below the reference in the lower or upper half, at or
   // above it toward yellow or toward red.
   localparam logic [1:0] CASE_BLUE   = 2'd0;
   localparam logic [1:0] CASE_CYAN   = 2'd1;
   localparam logic [1:0] CASE_YELLOW = 2'd2;
   localparam logic [1:0] CASE_RED    = 2'd3;

   // Configuration registers.
   logic signed [VALUE_BITS-1:0] min_ff, max_ff;
   logic [COUNT_BITS-1:0]        count_ff;

   // Sequencer and datapath registers.
   logic [2:0]                   state_ff, state_in;
   logic                         second_ff, second_in;
   logic signed [VALUE_BITS-1:0] sample_ff, sample_in;
   logic signed [VALUE_BITS-1:0] refv_ff, refv_in;
   logic signed [PW-1:0]         nd_ff, nd_in;
   logic signed [PW-1:0]         lhs_ff, lhs_in;
   logic [UW-1:0]                rem_ff, rem_in;
   logic [UW-1:0]                dvs_ff, dvs_in;
   logic [CQ-1:0]                q_ff, q_in;
   logic [CNTW-1:0]              cnt_ff, cnt_in;
   logic [GROUP_BITS-1:0]        g_ff, g_in;
   logic [GROUP_BITS-1:0]        z_ff, z_in;
   logic [1:0]                   case_ff, case_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_data_type                 rsp_data_ff, rsp_data_in;

   // Derived values.
   logic [GROUP_BITS-1:0]        n;
   logic signed [DW-1:0]         d;
   logic signed [DW-1:0]         diff;
   logic signed [DW-1:0]         mul_a;
   logic signed [PW-1:0]         prod;
   logic signed [DW-1:0]         mid_sum;
   logic signed [HW-1:0]         whole;
   logic signed [HW-2:0]         half;
   logic [UW:0]                  trial;
   logic                         qbit;
   logic                         grp_store;
   logic [GROUP_BITS-1:0]        grp_val;
   logic [GROUP_BITS:0]          zmid;
   logic [GROUP_BITS-1:0]        den;
   logic [NUMW-1:0]              num;
   logic [1:0]                   case_sel;
   logic [CW-1:0]                up;
   logic [CHAN_BITS-1:0]         up_ch;
   logic [CHAN_BITS-1:0]         dn_ch;

   // Configuration writes. Indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= '0;
         max_ff   <= VALUE_BITS'(6553600);
         count_ff <= COUNT_BITS'(10);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_VALUE:   min_ff   <= csr_wdata;
            CSR_MAX_VALUE:   max_ff   <= csr_wdata;
            CSR_COLOR_COUNT: count_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Group count, with the color count clamped to 2..256.
   always_comb begin
      if (count_ff < COUNT_BITS'(2)) begin
         n = GROUP_BITS'(1);
      end else if (count_ff > COUNT_BITS'(256)) begin
         n = GROUP_BITS'(255);
      end else begin
         n = GROUP_BITS'(count_ff - COUNT_BITS'(1));
      end
   end

   assign d    = DW'(max_ff) - DW'(min_ff);
   assign diff = (second_ff ? DW'(refv_ff) : DW'(sample_ff)) - DW'(min_ff);

   // The single multiplier forms n times the span, then n times the
   // distance of the current value from the lower end.
   assign mul_a = (state_ff == ST_ND) ? d : diff;
   assign prod  = PW'(mul_a) * PW'($signed({1'b0, n}));

   // Truncated midpoint: divide the sum by one unit, then by two, each
   // rounding toward zero, and scale back to Q16.16.
   always_comb begin
      mid_sum = DW'(min_ff) + DW'(max_ff);
      whole   = HW'(mid_sum >>> Q_FRAC);
      if (mid_sum[DW-1] && (|mid_sum[Q_FRAC-1:0])) begin
         whole = whole + HW'(1);
      end
      half = (HW-1)'(whole >>> 1);
      if (whole[HW-1] && whole[0]) begin
         half = half + (HW-1)'(1);
      end
   end

   // The shared restoring-division step.
   assign trial = {1'b0, rem_ff} - {1'b0, dvs_ff};
   assign qbit  = ~trial[UW];

   // Color case, numerator and divisor from the two groups.
   always_comb begin
      zmid = ({1'b0, n} + {1'b0, z_ff}) >> 1;
      if (g_ff < z_ff) begin
         den = n;
         if (g_ff < (z_ff >> 1)) begin
            case_sel = CASE_BLUE;
            num      = NUMW'(g_ff) * NUMW'(SPAN);
         end else begin
            case_sel = CASE_CYAN;
            num      = NUMW'(z_ff - g_ff) * NUMW'(SPAN) + NUMW'(n) - NUMW'(1);
         end
      end else begin
         den = n - z_ff;
         if ({1'b0, g_ff} <= zmid) begin
            case_sel = CASE_YELLOW;
            num      = NUMW'(g_ff - z_ff) * NUMW'(2 * SPAN);
         end else begin
            case_sel = CASE_RED;
            num      = NUMW'(n - g_ff) * NUMW'(2 * SPAN);
         end
      end
   end

   // Channel values from the quotient, clamped to the color range.
   always_comb begin
      up = CW'(BASE_LOW) + CW'(q_ff);
      if (up > CW'(BASE_HIGH)) begin
         up_ch = CHAN_BITS'(BASE_HIGH);
      end else begin
         up_ch = up[CHAN_BITS-1:0];
      end
      if (q_ff > CQ'(BASE_HIGH - BASE_LOW)) begin
         dn_ch = CHAN_BITS'(BASE_LOW);
      end else begin
         dn_ch = CHAN_BITS'(CQ'(BASE_HIGH) - q_ff);
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      second_in    = second_ff;
      sample_in    = sample_ff;
      refv_in      = refv_ff;
      nd_in        = nd_ff;
      lhs_in       = lhs_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      g_in         = g_ff;
      z_in         = z_ff;
      case_in      = case_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      grp_store    = 1'b0;
      grp_val      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sample_in = req_data.sample_value;
               if (req_data.nominal_given) begin
                  refv_in = req_data.nominal_value;
               end else begin
                  refv_in = {half, {Q_FRAC{1'b0}}};
               end
               second_in = 1'b0;
               state_in  = ST_ND;
            end
         end
         ST_ND: begin
            nd_in    = prod;
            state_in = ST_LHS;
         end
         ST_LHS: begin
            lhs_in   = prod;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // An empty or inverted range, a value below the range, or one
            // at or past the last group all give group zero.
            if ((d <= DW'(0)) || lhs_ff[PW-1] || (lhs_ff >= nd_ff)) begin
               grp_store = 1'b1;
               grp_val   = '0;
            end else begin
               rem_in   = lhs_ff[UW-1:0];
               dvs_in   = UW'(d[VALUE_BITS-1:0]) << (GQ - 1);
               q_in     = '0;
               cnt_in   = CNTW'(GQ - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (qbit) begin
               rem_in = trial[UW-1:0];
            end
            dvs_in = dvs_ff >> 1;
            q_in   = {q_ff[CQ-2:0], qbit};
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == '0) begin
               grp_store = 1'b1;
               grp_val   = {q_ff[GQ-2:0], qbit};
            end
         end
         ST_CSET: begin
            case_in  = case_sel;
            rem_in   = UW'(num);
            dvs_in   = UW'({den, {(CQ-1){1'b0}}});
            q_in     = '0;
            cnt_in   = CNTW'(CQ - 1);
            state_in = ST_CDIV;
         end
         ST_CDIV: begin
            if (qbit) begin
               rem_in = trial[UW-1:0];
            end
            dvs_in = dvs_ff >> 1;
            q_in   = {q_ff[CQ-2:0], qbit};
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_data_in.value_group     = g_ff;
            rsp_data_in.reference_group = z_ff;
            case (case_ff)
               CASE_BLUE: begin
                  rsp_data_in.red   = CHAN_BITS'(BASE_LOW);
                  rsp_data_in.green = up_ch;
                  rsp_data_in.blue  = CHAN_BITS'(BASE_HIGH);
               end
               CASE_CYAN: begin
                  rsp_data_in.red   = CHAN_BITS'(BASE_LOW);
                  rsp_data_in.green = CHAN_BITS'(BASE_HIGH);
                  rsp_data_in.blue  = dn_ch;
               end
               CASE_YELLOW: begin
                  rsp_data_in.red   = up_ch;
                  rsp_data_in.green = CHAN_BITS'(BASE_HIGH);
                  rsp_data_in.blue  = CHAN_BITS'(BASE_LOW);
               end
               default: begin
                  rsp_data_in.red   = CHAN_BITS'(BASE_HIGH);
                  rsp_data_in.green = up_ch;
                  rsp_data_in.blue  = CHAN_BITS'(BASE_LOW);
               end
            endcase
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A finished search stores the sample group and moves on to the
      // reference, or stores the reference group and sets up the color.
      if (grp_store) begin
         if (second_ff) begin
            z_in     = grp_val;
            state_in = ST_CSET;
         end else begin
            g_in      = grp_val;
            second_in = 1'b1;
            state_in  = ST_LHS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      refv_ff     <= refv_in;
      nd_ff       <= nd_in;
      lhs_ff      <= lhs_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      g_ff        <= g_in;
      z_ff        <= z_in;
      case_ff     <= case_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
